// ----- hdl/stscn_pkg.sv -----
// Package for the script token scanner: sizes, transfer payload types,
// token and error codes, and the control structs between scanner and name table.
// No dependencies.
package stscn_pkg;

  // Name table and name buffer sizes
  localparam int TABLE_ENTRIES = 128;
  localparam int NAME_CHARS    = 32;
  localparam int NAME_WORDS    = (NAME_CHARS + 7) / 8;
  localparam int NAME_BITS     = NAME_WORDS * 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int LEN_W         = $clog2(NAME_CHARS + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [IDX_W:0]   cnt_t;
  typedef logic [LEN_W-1:0] len_t;

  // Token kinds with a fixed meaning
  localparam logic [5:0] KIND_NULL   = 6'd0;
  localparam logic [5:0] KIND_END    = 6'd1;
  localparam logic [5:0] KIND_IDENT  = 6'd3;
  localparam logic [5:0] KIND_STRING = 6'd14;
  localparam logic [5:0] KIND_NUMBER = 6'd15;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN  = 3'd1;
  localparam logic [2:0] ERR_UNTERM   = 3'd2;
  localparam logic [2:0] ERR_FULL     = 3'd3;
  localparam logic [2:0] ERR_TOO_LONG = 3'd4;
  localparam logic [2:0] ERR_SAT      = 3'd5;

  localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [30:0] token_value;
    logic [31:0] line_number;
    logic [2:0]  error_code;
    logic        last;
  } tok_t;

  // Probe that walks the name table chain
  typedef struct packed {
    logic v;
    logic hit;
    idx_t hit_idx;
    idx_t pos;
  } probe_t;

  // Scanner requests to the name table
  typedef struct packed {
    logic                 start;
    logic                 wr_en;
    idx_t                 wr_idx;
    cnt_t                 nfree;
    logic [NAME_BITS-1:0] key;
  } tbl_req_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMB,
    MODE_OP,
    MODE_STR,
    MODE_CMT
  } mode_e;

  typedef enum logic [2:0] {
    ST_READY,
    ST_STEP,
    ST_SEARCH,
    ST_FINISH,
    ST_FLUSH
  } state_e;

endpackage

// ----- hdl/script_token_scanner.sv -----
// Top level of the script token scanner: scanner sequencer plus the name table
// built as a chain of cells. Depends on stscn_pkg, stscn_cell, stscn_core.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o  | in_data_i  (ch, end_of_text)
//   out     | output    | out_valid_o/out_stall_i| out_data_o (token fields, last)
//
// An item is accepted, gets one or two scan passes, then releases its last
// token. An identifier that is not a keyword also walks the search probe
// down the cell chain.
// Reset clears scanner state; the name table is not cleared, entries at or past
// the fill count are never compared. A stalled output holds the pass that
// needs it, and intake stalls until the item is done.
module script_token_scanner (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  stscn_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output stscn_pkg::tok_t out_data_o
);

  stscn_pkg::tbl_req_t tbl_req;
  stscn_pkg::probe_t   chain [stscn_pkg::TABLE_ENTRIES+1];

  stscn_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .tbl_o       (tbl_req),
    .tbl_res_i   (chain[stscn_pkg::TABLE_ENTRIES])
  );

  // Launch the probe at the head of the chain
  assign chain[0].v       = tbl_req.start;
  assign chain[0].hit     = 1'b0;
  assign chain[0].hit_idx = '0;
  assign chain[0].pos     = '0;

  for (genvar i = 0; i < stscn_pkg::TABLE_ENTRIES; i++) begin : g_cell
    logic in_use;
    logic wr_en;
    assign in_use = (i != 0) && (stscn_pkg::cnt_t'(i) < tbl_req.nfree);
    assign wr_en  = tbl_req.wr_en && (tbl_req.wr_idx == stscn_pkg::idx_t'(i));
    stscn_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .probe_i  (chain[i]),
      .key_i    (tbl_req.key),
      .in_use_i (in_use),
      .wr_en_i  (wr_en),
      .probe_o  (chain[i+1])
    );
  end

  a_wr_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_req.wr_en |-> (tbl_req.nfree < stscn_pkg::cnt_t'(stscn_pkg::TABLE_ENTRIES)))
    else $error("name table append past its last entry");

  a_one_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_req.start |=> !tbl_req.start)
    else $error("search launched on two cycles in a row");

  a_no_wr_on_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_req.start |-> !tbl_req.wr_en)
    else $error("append and search launch in the same cycle");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("intake open right after a transfer");

endmodule

// ----- hdl/stscn_cell.sv -----
// One name table cell: holds one stored name and compares it with the key
// as the search probe passes by. Depends on stscn_pkg.
module stscn_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  stscn_pkg::probe_t              probe_i,
  input  logic [stscn_pkg::NAME_BITS-1:0] key_i,
  input  logic                           in_use_i,
  input  logic                           wr_en_i,
  output stscn_pkg::probe_t              probe_o
);

  logic [stscn_pkg::NAME_BITS-1:0] entry_q;
  stscn_pkg::probe_t probe_d, probe_q;

  // Store the name when this cell is appended
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q <= key_i;
    end
  end

  // Mark a hit here unless an earlier cell already hit, and advance the probe
  always_comb begin
    probe_d.v       = probe_i.v;
    probe_d.hit     = probe_i.hit | (probe_i.v & in_use_i & (entry_q == key_i));
    probe_d.hit_idx = probe_i.hit ? probe_i.hit_idx : probe_i.pos;
    probe_d.pos     = probe_i.pos + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  assign probe_o = probe_q;

endmodule

// ----- hdl/stscn_core.sv -----
// Scanner sequencer: mode register, name buffer, number accumulator, counters,
// pending token and output register. Depends on stscn_pkg.
module stscn_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  stscn_pkg::in_t      in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output stscn_pkg::tok_t     out_data_o,
  output stscn_pkg::tbl_req_t tbl_o,
  input  stscn_pkg::probe_t   tbl_res_i
);

  localparam logic [63:0] KW_TEXT [12] = '{
    64'h0, "function", "var", "if", "else", "while",
    "for", "do", "in", "break", "continue", "return"
  };
  localparam logic [3:0] KW_LEN [12] = '{
    4'd0, 4'd8, 4'd3, 4'd2, 4'd4, 4'd5, 4'd3, 4'd2, 4'd2, 4'd5, 4'd8, 4'd6
  };
  localparam logic [5:0] KW_KIND [12] = '{
    6'd0, 6'd2, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13
  };

  // Keyword index of the buffered name, zero for none
  function automatic logic [3:0] kw_lookup(input logic [63:0] nm, input stscn_pkg::len_t len);
    logic [3:0] res;
    logic       same;
    res = 4'd0;
    for (int j = 1; j < 12; j++) begin
      same = (len == stscn_pkg::len_t'(KW_LEN[j]));
      for (int k = 0; k < 8; k++) begin
        if (k < int'(KW_LEN[j])) begin
          if (nm[k*8 +: 8] != KW_TEXT[j][(int'(KW_LEN[j]) - 1 - k)*8 +: 8]) begin
            same = 1'b0;
          end
        end
      end
      if (same && res == 4'd0) begin
        res = 4'(j);
      end
    end
    return res;
  endfunction

  function automatic logic [5:0] op_start(input logic [7:0] c);
    case (c)
      "=":     return 6'd2;
      "!":     return 6'd5;
      "+":     return 6'd8;
      "-":     return 6'd11;
      "<":     return 6'd14;
      ">":     return 6'd16;
      "%":     return 6'd18;
      "*":     return 6'd20;
      "&":     return 6'd22;
      "|":     return 6'd24;
      default: return 6'd0;
    endcase
  endfunction

  function automatic logic [5:0] single_delim(input logic [7:0] c);
    case (c)
      "[":     return 6'd26;
      "]":     return 6'd27;
      "(":     return 6'd28;
      ")":     return 6'd29;
      ",":     return 6'd30;
      ";":     return 6'd31;
      "{":     return 6'd32;
      "}":     return 6'd33;
      default: return 6'd0;
    endcase
  endfunction

  function automatic logic [5:0] op_extend(input logic [5:0] idx, input logic [7:0] c);
    case (idx)
      6'd2, 6'd3, 6'd5, 6'd6:          return (c == "=") ? idx + 6'd1 : 6'd0;
      6'd8:                            return (c == "=") ? 6'd9 : ((c == "+") ? 6'd10 : 6'd0);
      6'd11:                           return (c == "=") ? 6'd12 : ((c == "-") ? 6'd13 : 6'd0);
      6'd14, 6'd16, 6'd18, 6'd20:      return (c == "=") ? idx + 6'd1 : 6'd0;
      6'd22:                           return (c == "&") ? 6'd23 : 6'd0;
      6'd24:                           return (c == "|") ? 6'd25 : 6'd0;
      default:                         return 6'd0;
    endcase
  endfunction

  function automatic logic [5:0] dlm_kind(input logic [5:0] j);
    case (j)
      6'd1:  return 6'd1;   6'd2:  return 6'd17;  6'd3:  return 6'd18;
      6'd4:  return 6'd19;  6'd5:  return 6'd44;  6'd6:  return 6'd45;
      6'd7:  return 6'd46;  6'd8:  return 6'd24;  6'd9:  return 6'd47;
      6'd10: return 6'd29;  6'd11: return 6'd25;  6'd12: return 6'd48;
      6'd13: return 6'd30;  6'd14: return 6'd35;  6'd15: return 6'd38;
      6'd16: return 6'd36;  6'd17: return 6'd39;  6'd18: return 6'd28;
      6'd19: return 6'd49;  6'd20: return 6'd26;  6'd21: return 6'd50;
      6'd22: return 6'd51;  6'd23: return 6'd52;  6'd24: return 6'd53;
      6'd25: return 6'd54;  6'd26: return 6'd20;  6'd27: return 6'd21;
      6'd28: return 6'd22;  6'd29: return 6'd23;  6'd30: return 6'd43;
      6'd31: return 6'd16;  6'd32: return 6'd55;  6'd33: return 6'd56;
      default: return 6'd0;
    endcase
  endfunction

  stscn_pkg::state_e               state_d, state_q;
  stscn_pkg::mode_e                mode_d, mode_q;
  logic [7:0]                      ch_d, ch_q;
  logic                            eof_d, eof_q;
  logic [stscn_pkg::NAME_BITS-1:0] name_d, name_q;
  stscn_pkg::len_t                 len_d, len_q;
  logic                            ovf_d, ovf_q;
  logic [30:0]                     acc_d, acc_q;
  logic                            sat_d, sat_q;
  logic [31:0]                     line_d, line_q;
  logic [30:0]                     scnt_d, scnt_q;
  stscn_pkg::cnt_t                 nfree_d, nfree_q;
  logic [5:0]                      op_d, op_q;
  logic                            hit_d, hit_q;
  stscn_pkg::idx_t                 hidx_d, hidx_q;
  logic                            pend_v_d, pend_v_q;
  stscn_pkg::tok_t                 pend_d, pend_q;
  logic                            out_v_d, out_v_q;
  stscn_pkg::tok_t                 out_d, out_q;

  logic            out_free;
  logic            emit, go, push, start, wr_en;
  stscn_pkg::tok_t tok, push_tok;
  logic [34:0]     prod;
  logic [5:0]      t;
  logic [3:0]      kw;

  assign out_free = !out_v_q || !out_stall_i;

  // Next state: one scan pass per cycle while no token is held up, tokens staged through the pending slot
  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    ch_d     = ch_q;
    eof_d    = eof_q;
    name_d   = name_q;
    len_d    = len_q;
    ovf_d    = ovf_q;
    acc_d    = acc_q;
    sat_d    = sat_q;
    line_d   = line_q;
    scnt_d   = scnt_q;
    nfree_d  = nfree_q;
    op_d     = op_q;
    hit_d    = hit_q;
    hidx_d   = hidx_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    out_v_d  = out_v_q && out_stall_i;
    out_d    = out_q;
    emit     = 1'b0;
    push     = 1'b0;
    push_tok = pend_q;
    start    = 1'b0;
    wr_en    = 1'b0;
    tok      = '0;
    tok.line_number = line_q;
    prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + 35'(ch_q[3:0]);
    t    = eof_q ? 6'd0 : op_extend(op_q, ch_q);
    kw   = ovf_q ? 4'd0 : kw_lookup(name_q[63:0], len_q);

    unique case (state_q)
      stscn_pkg::ST_READY: begin
        if (in_valid_i) begin
          ch_d    = in_data_i.ch;
          eof_d   = in_data_i.end_of_text;
          state_d = stscn_pkg::ST_STEP;
        end
      end
      stscn_pkg::ST_STEP: begin
        state_d = stscn_pkg::ST_FLUSH;
        case (mode_q)
          stscn_pkg::MODE_IDENT: begin
            if (!eof_q && ((ch_q >= "a" && ch_q <= "z") || (ch_q >= "A" && ch_q <= "Z") ||
                           (ch_q >= "0" && ch_q <= "9"))) begin
              if (len_q < stscn_pkg::len_t'(stscn_pkg::NAME_CHARS)) begin
                for (int k = 0; k < stscn_pkg::NAME_CHARS; k++) begin
                  if (stscn_pkg::len_t'(k) == len_q) name_d[k*8 +: 8] = ch_q;
                end
                len_d = len_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end else if (kw != 4'd0) begin
              emit              = 1'b1;
              tok.token_kind    = KW_KIND[kw];
              tok.token_value   = 31'(kw);
              mode_d            = stscn_pkg::MODE_IDLE;
              state_d           = stscn_pkg::ST_STEP;
            end else begin
              start   = 1'b1;
              state_d = stscn_pkg::ST_SEARCH;
            end
          end
          stscn_pkg::MODE_NUMB: begin
            if (!eof_q && ch_q >= "0" && ch_q <= "9") begin
              if (prod > 35'(stscn_pkg::VALUE_MAX)) begin
                acc_d = stscn_pkg::VALUE_MAX;
                sat_d = 1'b1;
              end else begin
                acc_d = prod[30:0];
              end
            end else begin
              emit            = 1'b1;
              tok.token_kind  = stscn_pkg::KIND_NUMBER;
              tok.token_value = acc_q;
              tok.error_code  = sat_q ? stscn_pkg::ERR_SAT : stscn_pkg::ERR_NONE;
              mode_d          = stscn_pkg::MODE_IDLE;
              state_d         = stscn_pkg::ST_STEP;
            end
          end
          stscn_pkg::MODE_OP: begin
            if (t == 6'd0) begin
              emit            = 1'b1;
              tok.token_kind  = dlm_kind(op_q);
              tok.token_value = 31'(op_q);
              mode_d          = stscn_pkg::MODE_IDLE;
              state_d         = stscn_pkg::ST_STEP;
            end else if (t == 6'd3 || t == 6'd6) begin
              op_d = t;
            end else begin
              emit            = 1'b1;
              tok.token_kind  = dlm_kind(t);
              tok.token_value = 31'(t);
              mode_d          = stscn_pkg::MODE_IDLE;
            end
          end
          stscn_pkg::MODE_STR: begin
            if (eof_q) begin
              emit           = 1'b1;
              tok.error_code = stscn_pkg::ERR_UNTERM;
              mode_d         = stscn_pkg::MODE_IDLE;
              state_d        = stscn_pkg::ST_STEP;
            end else if (ch_q == "\"") begin
              emit            = 1'b1;
              tok.token_kind  = stscn_pkg::KIND_STRING;
              tok.token_value = scnt_q;
              scnt_d          = scnt_q + 1'b1;
              mode_d          = stscn_pkg::MODE_IDLE;
            end
          end
          stscn_pkg::MODE_CMT: begin
            if (eof_q || ch_q == 8'd10) begin
              mode_d  = stscn_pkg::MODE_IDLE;
              state_d = stscn_pkg::ST_STEP;
            end
          end
          default: begin
            mode_d = stscn_pkg::MODE_IDLE;
            if (eof_q) begin
              emit           = 1'b1;
              tok.token_kind = stscn_pkg::KIND_END;
            end else if (ch_q == " " || ch_q == 8'd13 || ch_q == 8'd9) begin
              mode_d = stscn_pkg::MODE_IDLE;
            end else if (ch_q == 8'd10) begin
              line_d = line_q + 1'b1;
            end else if ((ch_q >= "a" && ch_q <= "z") || (ch_q >= "A" && ch_q <= "Z")) begin
              name_d        = '0;
              name_d[7:0]   = ch_q;
              len_d         = stscn_pkg::len_t'(1);
              ovf_d         = 1'b0;
              mode_d        = stscn_pkg::MODE_IDENT;
            end else if (ch_q >= "0" && ch_q <= "9") begin
              acc_d  = 31'(ch_q[3:0]);
              sat_d  = 1'b0;
              mode_d = stscn_pkg::MODE_NUMB;
            end else if (ch_q == "#") begin
              mode_d = stscn_pkg::MODE_CMT;
            end else if (ch_q == "\"") begin
              mode_d = stscn_pkg::MODE_STR;
            end else if (op_start(ch_q) != 6'd0) begin
              op_d   = op_start(ch_q);
              mode_d = stscn_pkg::MODE_OP;
            end else if (single_delim(ch_q) != 6'd0) begin
              emit            = 1'b1;
              tok.token_kind  = dlm_kind(single_delim(ch_q));
              tok.token_value = 31'(single_delim(ch_q));
            end else begin
              emit            = 1'b1;
              tok.token_kind  = stscn_pkg::KIND_NULL;
              tok.token_value = 31'(ch_q);
              tok.error_code  = stscn_pkg::ERR_UNKNOWN;
            end
          end
        endcase
      end
      stscn_pkg::ST_SEARCH: begin
        if (tbl_res_i.v) begin
          hit_d   = tbl_res_i.hit;
          hidx_d  = tbl_res_i.hit_idx;
          state_d = stscn_pkg::ST_FINISH;
        end
      end
      stscn_pkg::ST_FINISH: begin
        emit           = 1'b1;
        mode_d         = stscn_pkg::MODE_IDLE;
        state_d        = stscn_pkg::ST_STEP;
        tok.token_kind = stscn_pkg::KIND_IDENT;
        tok.error_code = ovf_q ? stscn_pkg::ERR_TOO_LONG : stscn_pkg::ERR_NONE;
        if (hit_q) begin
          tok.token_value = 31'(hidx_q);
        end else if (nfree_q < stscn_pkg::cnt_t'(stscn_pkg::TABLE_ENTRIES)) begin
          wr_en           = 1'b1;
          nfree_d         = nfree_q + 1'b1;
          tok.token_value = 31'(nfree_q);
        end else begin
          tok.token_value = '0;
          tok.error_code  = stscn_pkg::ERR_FULL;
        end
      end
      stscn_pkg::ST_FLUSH: begin
        if (!pend_v_q) begin
          state_d = stscn_pkg::ST_READY;
        end else if (out_free) begin
          push          = 1'b1;
          push_tok.last = 1'b1;
          pend_v_d      = 1'b0;
          state_d       = stscn_pkg::ST_READY;
        end
      end
      default: state_d = stscn_pkg::ST_READY;
    endcase

    // Hold the whole pass when a token has nowhere to go
    go = !emit || !pend_v_q || out_free;
    if (!go) begin
      state_d = state_q;
      mode_d  = mode_q;
      name_d  = name_q;
      len_d   = len_q;
      ovf_d   = ovf_q;
      acc_d   = acc_q;
      sat_d   = sat_q;
      line_d  = line_q;
      scnt_d  = scnt_q;
      nfree_d = nfree_q;
      op_d    = op_q;
      start   = 1'b0;
      wr_en   = 1'b0;
    end else if (emit) begin
      if (pend_v_q) begin
        push = 1'b1;
      end
      pend_d   = tok;
      pend_v_d = 1'b1;
    end

    if (push) begin
      out_v_d = 1'b1;
      out_d   = push_tok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= stscn_pkg::ST_READY;
      mode_q   <= stscn_pkg::MODE_IDLE;
      len_q    <= '0;
      ovf_q    <= 1'b0;
      sat_q    <= 1'b0;
      acc_q    <= '0;
      line_q   <= 32'd1;
      scnt_q   <= '0;
      nfree_q  <= stscn_pkg::cnt_t'(1);
      op_q     <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      name_q   <= '0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      len_q    <= len_d;
      ovf_q    <= ovf_d;
      sat_q    <= sat_d;
      acc_q    <= acc_d;
      line_q   <= line_d;
      scnt_q   <= scnt_d;
      nfree_q  <= nfree_d;
      op_q     <= op_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      name_q   <= name_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    eof_q  <= eof_d;
    hit_q  <= hit_d;
    hidx_q <= hidx_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != stscn_pkg::ST_READY);
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  assign tbl_o.start  = start;
  assign tbl_o.wr_en  = wr_en;
  assign tbl_o.wr_idx = nfree_q[stscn_pkg::IDX_W-1:0];
  assign tbl_o.nfree  = nfree_q;
  assign tbl_o.key    = name_q;

endmodule

// ----- bench/tb_top.sv -----
// Testbench for the script token scanner: directed and random source text,
// a built-in token predictor, and a checker on every output transfer.
// Depends on stscn_pkg and script_token_scanner.
`timescale 1ns / 100ps

module tb_top;

  localparam int  LIMIT_CYCLES = 3000000;
  localparam int  RANDOM_ITEMS = 480;

  localparam bit [5:0] DLM_KIND [34] = '{
    0, 1, 17, 18, 19, 44, 45, 46, 24, 47,
    29, 25, 48, 30, 35, 38, 36, 39, 28, 49,
    26, 50, 51, 52, 53, 54, 20, 21, 22, 23,
    43, 16, 55, 56};
  localparam int KW_COUNT = 12;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  stscn_pkg::in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  stscn_pkg::tok_t out_data_o;

  script_token_scanner uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Scanner shadow state
  stscn_pkg::mode_e                scan_md;
  bit [stscn_pkg::NAME_BITS-1:0]   word_buf;
  int                              word_len;
  bit                              word_ovf;
  bit [30:0]                       num_acc;
  bit                              num_sat;
  bit [31:0]                       line_cnt;
  bit [30:0]                       str_cnt;
  int                              free_slot;
  int                              op_idx;
  bit [stscn_pkg::NAME_BITS-1:0]   names [stscn_pkg::TABLE_ENTRIES];
  string                           kw_text [KW_COUNT];

  stscn_pkg::tok_t step_toks[$];
  stscn_pkg::tok_t expected_toks[$];
  int   err_count = 0;
  int   cycle_count = 0;
  bit   no_gaps = 1'b0;
  int   items_sent = 0;

  // Idle lengths: mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void emit(bit [5:0] kind, bit [30:0] value, bit [2:0] err);
    stscn_pkg::tok_t t;
    if (step_toks.size() >= 2) return;
    t.token_kind = kind;
    t.token_value = value;
    t.line_number = line_cnt;
    t.error_code = err;
    t.last = 1'b0;
    step_toks.insert(step_toks.size(), t);
  endfunction

  function automatic void emit_delim(int j);
    emit((j < 34) ? DLM_KIND[j] : stscn_pkg::KIND_NULL, 31'(j), stscn_pkg::ERR_NONE);
  endfunction

  function automatic bit is_alpha(bit [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(bit [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Look up a finished name: keyword, known entry, new entry or full table
  function automatic void close_name();
    bit [stscn_pkg::NAME_BITS-1:0] kw;
    int j, k;
    if (!word_ovf) begin
      for (j = 1; j < KW_COUNT; j++) begin
        kw = '0;
        for (k = 0; k < kw_text[j].len(); k++) kw[8*k +: 8] = kw_text[j][k];
        if (kw_text[j].len() == word_len && kw == word_buf) begin
          emit((j == 1) ? 6'd2 : 6'(j + 2), 31'(j), stscn_pkg::ERR_NONE);
          return;
        end
      end
    end
    for (j = 1; j < free_slot && j < stscn_pkg::TABLE_ENTRIES; j++) begin
      if (names[j] == word_buf) begin
        emit(stscn_pkg::KIND_IDENT, 31'(j),
             word_ovf ? stscn_pkg::ERR_TOO_LONG : stscn_pkg::ERR_NONE);
        return;
      end
    end
    if (free_slot < stscn_pkg::TABLE_ENTRIES) begin
      names[free_slot] = word_buf;
      emit(stscn_pkg::KIND_IDENT, 31'(free_slot),
           word_ovf ? stscn_pkg::ERR_TOO_LONG : stscn_pkg::ERR_NONE);
      free_slot++;
    end else begin
      emit(stscn_pkg::KIND_IDENT, '0, stscn_pkg::ERR_FULL);
    end
  endfunction

  function automatic void add_char(bit [7:0] c);
    if (word_len < stscn_pkg::NAME_CHARS) begin
      word_buf[8*word_len +: 8] = c;
      word_len++;
    end else begin
      word_ovf = 1'b1;
    end
  endfunction

  function automatic int op_first(bit [7:0] c);
    case (c)
      "=": return 2;  "!": return 5;  "+": return 8;  "-": return 11;
      "<": return 14; ">": return 16; "%": return 18; "*": return 20;
      "&": return 22; "|": return 24;
      default: return 0;
    endcase
  endfunction

  function automatic int delim_single(bit [7:0] c);
    case (c)
      "[": return 26; "]": return 27; "(": return 28; ")": return 29;
      ",": return 30; ";": return 31; "{": return 32; "}": return 33;
      default: return 0;
    endcase
  endfunction

  function automatic int op_grow(int idx, bit [7:0] c);
    case (idx)
      2, 3, 5, 6: return (c == "=") ? idx + 1 : 0;
      8:  return (c == "=") ? 9 : ((c == "+") ? 10 : 0);
      11: return (c == "=") ? 12 : ((c == "-") ? 13 : 0);
      14, 16, 18, 20: return (c == "=") ? idx + 1 : 0;
      22: return (c == "&") ? 23 : 0;
      24: return (c == "|") ? 25 : 0;
      default: return 0;
    endcase
  endfunction

  // One scan pass; returns 1 when the byte must be scanned again
  function automatic bit scan_pass(bit [7:0] c, bit eot);
    int t;
    case (scan_md)
      stscn_pkg::MODE_IDENT: begin
        if (!eot && (is_alpha(c) || is_digit(c))) begin
          add_char(c);
          return 1'b0;
        end
        close_name();
        scan_md = stscn_pkg::MODE_IDLE;
        return 1'b1;
      end
      stscn_pkg::MODE_NUMB: begin
        if (!eot && is_digit(c)) begin
          longint v;
          v = longint'(num_acc) * 10 + longint'(c - "0");
          if (v > longint'(stscn_pkg::VALUE_MAX)) begin
            v = longint'(stscn_pkg::VALUE_MAX);
            num_sat = 1'b1;
          end
          num_acc = v[30:0];
          return 1'b0;
        end
        emit(stscn_pkg::KIND_NUMBER, num_acc,
             num_sat ? stscn_pkg::ERR_SAT : stscn_pkg::ERR_NONE);
        scan_md = stscn_pkg::MODE_IDLE;
        return 1'b1;
      end
      stscn_pkg::MODE_OP: begin
        t = eot ? 0 : op_grow(op_idx, c);
        if (t == 0) begin
          emit_delim(op_idx);
          scan_md = stscn_pkg::MODE_IDLE;
          return 1'b1;
        end
        if (t == 3 || t == 6) begin
          op_idx = t;
          return 1'b0;
        end
        emit_delim(t);
        scan_md = stscn_pkg::MODE_IDLE;
        return 1'b0;
      end
      stscn_pkg::MODE_STR: begin
        if (eot) begin
          emit(stscn_pkg::KIND_NULL, '0, stscn_pkg::ERR_UNTERM);
          scan_md = stscn_pkg::MODE_IDLE;
          return 1'b1;
        end
        if (c == "\"") begin
          emit(stscn_pkg::KIND_STRING, str_cnt, stscn_pkg::ERR_NONE);
          str_cnt++;
          scan_md = stscn_pkg::MODE_IDLE;
        end
        return 1'b0;
      end
      stscn_pkg::MODE_CMT: begin
        if (eot || c == 8'd10) begin
          scan_md = stscn_pkg::MODE_IDLE;
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        scan_md = stscn_pkg::MODE_IDLE;
        if (eot) begin
          emit(stscn_pkg::KIND_END, '0, stscn_pkg::ERR_NONE);
          return 1'b0;
        end
        if (c == " " || c == 8'd13 || c == 8'd9) return 1'b0;
        if (c == 8'd10) begin
          line_cnt++;
          return 1'b0;
        end
        if (is_alpha(c)) begin
          word_buf = '0;
          word_len = 0;
          word_ovf = 1'b0;
          add_char(c);
          scan_md = stscn_pkg::MODE_IDENT;
          return 1'b0;
        end
        if (is_digit(c)) begin
          num_acc = 31'(c - "0");
          num_sat = 1'b0;
          scan_md = stscn_pkg::MODE_NUMB;
          return 1'b0;
        end
        if (c == "#") begin
          scan_md = stscn_pkg::MODE_CMT;
          return 1'b0;
        end
        if (c == "\"") begin
          scan_md = stscn_pkg::MODE_STR;
          return 1'b0;
        end
        t = op_first(c);
        if (t != 0) begin
          op_idx = t;
          scan_md = stscn_pkg::MODE_OP;
          return 1'b0;
        end
        t = delim_single(c);
        if (t != 0) begin
          emit_delim(t);
          return 1'b0;
        end
        emit(stscn_pkg::KIND_NULL, 31'(c), stscn_pkg::ERR_UNKNOWN);
        return 1'b0;
      end
    endcase
  endfunction

  // Work out the tokens of one accepted item and queue them
  function automatic void predict_tokens(stscn_pkg::in_t d);
    int g;
    step_toks.delete();
    for (g = 0; g < 4; g++) if (!scan_pass(d.ch, d.end_of_text)) break;
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) expected_toks.insert(expected_toks.size(), step_toks[i]);
  endfunction

  // Send one item; returns at the edge that takes the transfer
  task automatic send_item(bit [7:0] c, bit eot);
    stscn_pkg::in_t d;
    int g;
    bit ok;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    d.ch = c;
    d.end_of_text = eot;
    in_valid_i <= 1'b1;
    in_data_i <= d;
    do begin
      @(negedge clk_i);
      ok = !in_stall_o;
      @(posedge clk_i);
    end while (!ok);
    predict_tokens(d);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_eot();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic string rand_name(int maxlen, int alpha_span);
    string s;
    int n;
    n = $urandom_range(1, maxlen);
    s = "";
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 3) == 0)
        s = {s, string'(8'($urandom_range("0", "9")))};
      else if ($urandom_range(0, 1))
        s = {s, string'(8'($urandom_range("a", "a" + alpha_span - 1)))};
      else
        s = {s, string'(8'($urandom_range("A", "A" + alpha_span - 1)))};
    end
    return s;
  endfunction

  task automatic test_keywords_and_names();
    send_text("function var if else while for do in break continue return\n");
    send_text("functions Var x1 x1 foo(bar)\n");
    send_text("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMN abcdefghijklmnopqrstuvwxyzABCDEFxyz\n");
    send_text("continue");
    send_eot();
  endtask

  task automatic test_operators();
    send_text("= == === ! != !== + += ++ - -= -- < <= > >= % %= * *= & && | || ");
    send_text("[](),;{} a=b!c====d!==e+++f---g&&&h|||\n");
    send_text("==");
    send_eot();
  endtask

  task automatic test_numbers_strings_comments();
    send_text("0 7 2147483647 2147483648 99999999999999 12x 3+\n");
    send_text("\"\" \"ab\ncd\" \"# not a comment\" # a comment \"x\n");
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_text("\"");
    send_item(8'hC3, 1'b0);
    send_text("\" @ $ ~\t\r\n");
    send_text("\"open");
    send_eot();
    send_eot();
    send_text("# comment at the end");
    send_eot();
    send_text("42");
    send_eot();
  endtask

  // Mostly well-formed token streams with random content, some raw noise
  task automatic test_random_text();
    string pool [24];
    string ops [26];
    int r, start;
    ops = '{"=", "==", "===", "!", "!=", "!==", "+", "+=", "++", "-", "-=", "--",
            "<", "<=", ">", ">=", "%", "%=", "*", "*=", "&", "&&", "|", "||",
            "(", ";"};
    foreach (pool[i]) pool[i] = rand_name(5, 4);
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) no_gaps = ~no_gaps;
      r = $urandom_range(0, 99);
      if (r < 20) send_text(pool[$urandom_range(0, 23)]);
      else if (r < 25) send_text(rand_name(12, 26));
      else if (r < 30) send_text(kw_text[$urandom_range(1, KW_COUNT - 1)]);
      else if (r < 40) send_text($sformatf("%0d", $urandom_range(0, 99999)));
      else if (r < 42) send_text("98765432109876");
      else if (r < 55) send_text(ops[$urandom_range(0, 25)]);
      else if (r < 60) send_text(string'(8'("[" + 0)));
      else if (r < 67) begin
        send_text("\"");
        repeat ($urandom_range(0, 5)) send_item(8'($urandom_range(0, 255)) & 8'hDD, 1'b0);
        send_text("\"");
      end
      else if (r < 70) send_text("# note\n");
      else if (r < 82) send_text(" ");
      else if (r < 88) send_text("\n");
      else if (r < 97) send_item(8'($urandom_range(0, 255)), 1'b0);
      else send_eot();
      if ($urandom_range(0, 3) == 0) send_text(" ");
    end
    send_eot();
  endtask

  task automatic test_table_full();
    no_gaps = 1'b0;
    for (int i = 0; i < stscn_pkg::TABLE_ENTRIES + 4; i++)
      send_text($sformatf("zq%0d ", i));
    send_text("zq3 brandnew");
    send_eot();
  endtask

  // Output side: random stall, check each transfer
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if ($urandom_range(0, 99) < 70 || no_gaps) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 9) != 0);
    if (cycle_count > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    stscn_pkg::tok_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_toks.size() == 0) begin
        $error("token transfer with nothing expected: kind %0d", out_data_o.token_kind);
        err_count++;
      end else begin
        e = expected_toks.pop_front();
        if (out_data_o.token_kind !== e.token_kind) begin
          $error("token_kind exp %0d got %0d", e.token_kind, out_data_o.token_kind);
          err_count++;
        end
        if (out_data_o.token_value !== e.token_value) begin
          $error("token_value exp %0d got %0d", e.token_value, out_data_o.token_value);
          err_count++;
        end
        if (out_data_o.line_number !== e.line_number) begin
          $error("line_number exp %0d got %0d", e.line_number, out_data_o.line_number);
          err_count++;
        end
        if (out_data_o.error_code !== e.error_code) begin
          $error("error_code exp %0d got %0d", e.error_code, out_data_o.error_code);
          err_count++;
        end
        if (out_data_o.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_data_o.last);
          err_count++;
        end
      end
    end
  end

  initial begin
    kw_text = '{"", "function", "var", "if", "else", "while",
                "for", "do", "in", "break", "continue", "return"};
    scan_md = stscn_pkg::MODE_IDLE;
    word_buf = '0;
    word_len = 0;
    word_ovf = 1'b0;
    num_acc = '0;
    num_sat = 1'b0;
    line_cnt = 32'd1;
    str_cnt = '0;
    free_slot = 1;
    op_idx = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_keywords_and_names();
    test_operators();
    test_numbers_strings_comments();
    test_random_text();
    test_table_full();
    in_valid_i <= 1'b0;
    while (expected_toks.size() != 0) @(posedge clk_i);
    repeat (stscn_pkg::TABLE_ENTRIES + 40) @(posedge clk_i);
    if (err_count == 0 && expected_toks.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/stscn_pkg.sv
hdl/stscn_cell.sv
hdl/stscn_core.sv
hdl/script_token_scanner.sv
bench/tb_top.sv
